>>> rtl/sfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slab allocator package
// Sizes, status codes and the request and response of the shared adder.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int SLABS_PER_GULP = 16;
  localparam int SLAB_BYTES     = 64;
  localparam int MAX_GULPS      = 8;
  localparam int TOTAL_SLABS    = SLABS_PER_GULP * MAX_GULPS;

  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int FCNT_W   = 8;
  localparam int GOUT_W   = 4;

  localparam int IDX_W      = (TOTAL_SLABS > 1) ? $clog2(TOTAL_SLABS) : 1;
  localparam int DEPTH_W    = $clog2(TOTAL_SLABS + 1);
  localparam int GCNT_W     = $clog2(MAX_GULPS + 1);
  localparam int SLOT_W     = (SLABS_PER_GULP > 1) ? $clog2(SLABS_PER_GULP) : 1;
  localparam int SLAB_SHIFT = $clog2(SLAB_BYTES);
  localparam int CHUNK_SHIFT = $clog2(SLABS_PER_GULP) + SLAB_SHIFT;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'd65536;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_GULPS = 3'd5;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t             op;
    logic [ADDR_W-1:0]   a;
    logic [ADDR_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   y;
    logic                carry;
  } alu_rsp_t;

endpackage
`default_nettype wire

>>> rtl/slab_free_list_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slab free-list allocator
// Fixed-size slab allocator with a LIFO free stack, refilled one gulp region
// at a time, and per-slab free marks for double-free detection.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  op, address
//   out      output     out_valid/out_ready  status, slab_address,
//                                            free_count, gulps_claimed
//   cfg      input      cfg_valid/cfg_ready  cfg_data (base_address)
//
// An allocate reads the stack top; on an empty stack it first pushes each slot of
// a new gulp and pops. A free computes its offset, checks bound and fill and, if
// both pass, reads its mark; a null free or an allocate with no gulps left goes
// straight to the result. in_ready is high only when idle; a result waiting in
// the output register holds the next item in its last cycle. Reset is
// synchronous, and free marks read as clear through per-slab valid bits; the
// stack RAM is never cleared.
// ----------------------------------------------------------------------------
module slab_free_list_allocator_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               op,
  input  wire logic [sfla_pkg::ADDR_W-1:0]        address,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [sfla_pkg::STATUS_W-1:0]      status,
  output logic      [sfla_pkg::ADDR_W-1:0]        slab_address,
  output logic      [sfla_pkg::FCNT_W-1:0]        free_count,
  output logic      [sfla_pkg::GOUT_W-1:0]        gulps_claimed,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sfla_pkg::ADDR_W-1:0]        cfg_data
);

  // Sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILL = 8'b0000_0010,
    S_POP  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_OFFS = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_MRD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Architectural state.
  logic [sfla_pkg::ADDR_W-1:0]  base;
  logic [sfla_pkg::DEPTH_W-1:0] depth;
  logic [sfla_pkg::GCNT_W-1:0]  gulps;
  logic [sfla_pkg::TOTAL_SLABS-1:0] mark_vld;

  // Per-item working registers.
  logic [sfla_pkg::ADDR_W-1:0]   addr_in;
  logic [sfla_pkg::ADDR_W-1:0]   offset;
  logic [sfla_pkg::SLOT_W-1:0]   slot;
  logic [sfla_pkg::STATUS_W-1:0] res_status;
  logic [sfla_pkg::ADDR_W-1:0]   res_addr;
  logic                          mvld_q;

  // Output register.
  logic [sfla_pkg::STATUS_W-1:0] out_status;
  logic [sfla_pkg::ADDR_W-1:0]   out_addr;
  logic [sfla_pkg::FCNT_W-1:0]   out_free;
  logic [sfla_pkg::GOUT_W-1:0]   out_gulps;

  // Memories and the shared adder.
  logic                         stack_we;
  logic [sfla_pkg::IDX_W-1:0]   stack_wdata;
  logic [sfla_pkg::IDX_W-1:0]   stack_q;
  logic                         mark_we;
  logic [sfla_pkg::IDX_W-1:0]   mark_waddr;
  logic                         mark_wdata;
  logic                         mark_q;
  sfla_pkg::alu_req_t           alu_req;
  sfla_pkg::alu_rsp_t           alu_rsp;

  // Derived values.
  logic [sfla_pkg::DEPTH_W-1:0] depth_m1;
  logic [sfla_pkg::DEPTH_W-1:0] claimed_slabs;
  logic [sfla_pkg::IDX_W-1:0]   fill_idx;
  logic [sfla_pkg::IDX_W-1:0]   free_idx;
  logic [sfla_pkg::ADDR_W-1:0]  limit;
  logic                         misaligned;
  logic                         mark_hit;
  logic                         slot_last;
  logic                         out_free_slot;

  assign depth_m1      = depth - 1'b1;
  assign claimed_slabs = sfla_pkg::DEPTH_W'(gulps)
                       * sfla_pkg::DEPTH_W'(sfla_pkg::SLABS_PER_GULP);
  assign fill_idx      = sfla_pkg::IDX_W'(claimed_slabs) + sfla_pkg::IDX_W'(slot);
  assign free_idx      = offset[sfla_pkg::SLAB_SHIFT +: sfla_pkg::IDX_W];
  assign limit         = sfla_pkg::ADDR_W'(gulps) << sfla_pkg::CHUNK_SHIFT;
  assign misaligned    = (offset & sfla_pkg::ADDR_W'(sfla_pkg::SLAB_BYTES - 1)) != '0;
  assign mark_hit      = mvld_q & mark_q;
  assign slot_last     = slot == sfla_pkg::SLOT_W'(sfla_pkg::SLABS_PER_GULP - 1);
  assign out_free_slot = !out_valid || out_ready;

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;

  assign status        = out_status;
  assign slab_address  = out_addr;
  assign free_count    = out_free;
  assign gulps_claimed = out_gulps;

  // The stack is always read at its top entry; the read data is registered and used in the following cycle.
  sfla_ram #(
    .WIDTH (sfla_pkg::IDX_W),
    .DEPTH (sfla_pkg::TOTAL_SLABS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (depth[sfla_pkg::IDX_W-1:0]),
    .wdata (stack_wdata),
    .raddr (depth_m1[sfla_pkg::IDX_W-1:0]),
    .rdata (stack_q)
  );

  // Free marks; an entry never written since reset reads as clear through
  // its valid bit.
  sfla_ram #(
    .WIDTH (1),
    .DEPTH (sfla_pkg::TOTAL_SLABS)
  ) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (free_idx),
    .rdata (mark_q)
  );

  sfla_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Memory write controls.
  always_comb begin
    stack_we    = (state == S_FILL) || ((state == S_MRD) && !mark_hit);
    stack_wdata = (state == S_FILL) ? fill_idx : free_idx;
    mark_we     = (state == S_FILL) || (state == S_RD) || ((state == S_MRD) && !mark_hit);
    mark_wdata  = state != S_RD;
    case (state)
      S_FILL:  mark_waddr = fill_idx;
      S_RD:    mark_waddr = stack_q;
      default: mark_waddr = free_idx;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.op = sfla_pkg::ALU_ADD;
    alu_req.a  = base;
    alu_req.b  = sfla_pkg::ADDR_W'(stack_q) << sfla_pkg::SLAB_SHIFT;
    case (state)
      S_OFFS: begin
        alu_req.op = sfla_pkg::ALU_SUB;
        alu_req.a  = addr_in;
        alu_req.b  = base;
      end
      S_CHK: begin
        alu_req.op = sfla_pkg::ALU_SUB;
        alu_req.a  = offset;
        alu_req.b  = limit;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op) begin
            state_next = (address == '0) ? S_DONE : S_OFFS;
          end else if (depth != '0) begin
            state_next = S_RD;
          end else if (gulps < sfla_pkg::GCNT_W'(sfla_pkg::MAX_GULPS)) begin
            state_next = S_FILL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_FILL: begin
        if (slot_last) begin
          state_next = S_POP;
        end
      end
      S_POP:  state_next = S_RD;
      S_RD:   state_next = S_DONE;
      S_OFFS: state_next = S_CHK;
      S_CHK: begin
        // A clear carry means the offset lies below the claimed limit.
        if (alu_rsp.carry || misaligned || depth == claimed_slabs) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MRD;
        end
      end
      S_MRD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free_slot) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= sfla_pkg::BASE_RESET;
      depth     <= '0;
      gulps     <= '0;
      mark_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
      if (mark_we) begin
        mark_vld[mark_waddr] <= 1'b1;
      end
      if (stack_we) begin
        depth <= depth + 1'b1;
      end else if ((state == S_IDLE && in_valid && !op && depth != '0) || state == S_POP) begin
        depth <= depth_m1;
      end
      if (state == S_FILL && slot_last) begin
        gulps <= gulps + 1'b1;
      end
      if (state == S_DONE && out_free_slot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mvld_q <= mark_vld[free_idx];
    case (state)
      S_IDLE: begin
        addr_in    <= address;
        slot       <= '0;
        res_addr   <= '0;
        res_status <= op ? sfla_pkg::ST_NULL : sfla_pkg::ST_NO_GULPS;
      end
      S_FILL: slot <= slot + 1'b1;
      S_RD: begin
        res_status <= sfla_pkg::ST_OK;
        res_addr   <= alu_rsp.y;
      end
      S_OFFS: offset <= alu_rsp.y;
      S_CHK: begin
        if (alu_rsp.carry || misaligned) begin
          res_status <= sfla_pkg::ST_OUTSIDE;
        end else if (depth == claimed_slabs) begin
          res_status <= sfla_pkg::ST_FULL;
        end
      end
      S_MRD: res_status <= mark_hit ? sfla_pkg::ST_DOUBLE : sfla_pkg::ST_OK;
      S_DONE: begin
        if (out_free_slot) begin
          out_status <= res_status;
          out_addr   <= res_addr;
          out_free   <= sfla_pkg::FCNT_W'(depth);
          out_gulps  <= sfla_pkg::GOUT_W'(gulps);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sfla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/sfla_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared adder
// 32-bit add or subtract with carry out; a set carry on subtract means a >= b.
// ----------------------------------------------------------------------------
module sfla_alu (
  input  wire sfla_pkg::alu_req_t req,
  output sfla_pkg::alu_rsp_t      rsp
);

  logic [sfla_pkg::ADDR_W-1:0] b_in;
  logic [sfla_pkg::ADDR_W:0]   sum;

  always_comb begin
    b_in = (req.op == sfla_pkg::ALU_SUB) ? ~req.b : req.b;
    sum  = {1'b0, req.a} + {1'b0, b_in}
         + (sfla_pkg::ADDR_W + 1)'(req.op == sfla_pkg::ALU_SUB);
    rsp.y     = sum[sfla_pkg::ADDR_W-1:0];
    rsp.carry = sum[sfla_pkg::ADDR_W];
  end

endmodule
`default_nettype wire

>>> dv/tb_slab_free_list_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab free-list allocator testbench
// Drives allocate and free items into the allocator under random idling on
// both handshakes. A mirror of the free stack, the free marks and the gulp
// count predicts each result, and every result that leaves the block is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_slab_free_list_allocator_unit;
  import sfla_pkg::*;

  // Operation codes of the op field.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // The limit is far beyond the slowest correct run, which leaves plenty of room
  // for the long receiver hold-off and the refills.
  localparam int CYCLE_LIMIT  = 200000;
  // A gulp refill is the longest piece of work, pushing every slot of the gulp,
  // so an idle stretch of this length at the end would show any stray result.
  localparam int DRAIN_CYCLES = 4 * SLABS_PER_GULP + 16;
  localparam int REPORT_CAP   = 200;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slab_address;
    logic [FCNT_W-1:0]   free_count;
    logic [GOUT_W-1:0]   gulps_claimed;
  } slab_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic [ADDR_W-1:0]   address;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   slab_address;
  logic [FCNT_W-1:0]   free_count;
  logic [GOUT_W-1:0]   gulps_claimed;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_data;

  slab_free_list_allocator_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .address       (address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slab_address  (slab_address),
    .free_count    (free_count),
    .gulps_claimed (gulps_claimed),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Mirror of the allocator's state. It is updated at the moment an item is
  // accepted, which is safe because the block works on one item at a time
  // and in order, and the base is only rewritten while the block is idle.
  logic [ADDR_W-1:0]  mirror_base;
  logic [IDX_W-1:0]   mirror_stack [TOTAL_SLABS];
  bit                 mirror_mark  [TOTAL_SLABS];
  logic [DEPTH_W-1:0] mirror_depth;
  logic [GCNT_W-1:0]  mirror_gulps;

  // Slab indices currently handed out, so that the random traffic can free
  // slabs that really are allocated rather than only noise.
  int unsigned owned_slabs [$];

  // Predicted results, oldest at the front.
  slab_result_t pending_slab_results [$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned allocs_sent;
  int unsigned frees_sent;
  int unsigned base_writes;
  int unsigned results_checked;
  int unsigned status_seen [6];

  // Idling controls. The receiver also honours a one-off hold-off request,
  // which it counts down itself.
  bit tx_idle_en;
  bit rx_idle_en;
  int unsigned rx_hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The watchdog: a run that has not finished by the limit has hung.
  initial begin : watchdog
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_slab_results.size());
    $display("slab_free_list_allocator_unit: mismatch");
    $finish;
  end

  // Byte address of a slab under the current base, wrapping at 32 bits.
  function automatic logic [ADDR_W-1:0] slab_addr(input int unsigned idx);
    return mirror_base + ADDR_W'(idx * SLAB_BYTES);
  endfunction

  // Works out the result of one accepted item and advances the mirror.
  function automatic slab_result_t predict_slab_result(input logic op_i,
                                                       input logic [ADDR_W-1:0] addr_i);
    slab_result_t      r;
    logic [ADDR_W-1:0] offset;
    int unsigned       idx;
    int unsigned       s;
    int                k;
    r.status       = ST_OK;
    r.slab_address = '0;
    if (op_i == OP_ALLOC) begin
      // An empty stack is refilled from the next gulp, lowest slot first,
      // so the highest slot of the gulp is the first to come back out.
      if (mirror_depth == 0 && mirror_gulps < MAX_GULPS) begin
        for (s = 0; s < SLABS_PER_GULP; s++) begin
          idx = mirror_gulps * SLABS_PER_GULP + s;
          mirror_stack[mirror_depth] = IDX_W'(idx);
          mirror_mark[idx] = 1'b1;
          mirror_depth++;
        end
        mirror_gulps++;
      end
      if (mirror_depth == 0) begin
        r.status = ST_NO_GULPS;
      end else begin
        mirror_depth--;
        idx = mirror_stack[mirror_depth];
        mirror_mark[idx] = 1'b0;
        r.slab_address = slab_addr(idx);
        owned_slabs = {owned_slabs, idx};
      end
    end else begin
      offset = addr_i - mirror_base;
      if (addr_i == '0) begin
        r.status = ST_NULL;
      end else if (offset >= mirror_gulps * SLABS_PER_GULP * SLAB_BYTES ||
                   offset % SLAB_BYTES != 0) begin
        r.status = ST_OUTSIDE;
      end else if (mirror_depth == mirror_gulps * SLABS_PER_GULP) begin
        r.status = ST_FULL;
      end else begin
        idx = offset / SLAB_BYTES;
        if (mirror_mark[idx]) begin
          r.status = ST_DOUBLE;
        end else begin
          mirror_stack[mirror_depth] = IDX_W'(idx);
          mirror_mark[idx] = 1'b1;
          mirror_depth++;
          for (k = 0; k < owned_slabs.size(); k++) begin
            if (owned_slabs[k] == idx) begin
              owned_slabs.delete(k);
              break;
            end
          end
        end
      end
    end
    r.free_count    = FCNT_W'(mirror_depth);
    r.gulps_claimed = GOUT_W'(mirror_gulps);
    return r;
  endfunction

  // Address for a random free: mostly a slab that is really allocated, the
  // rest null, misaligned, wild, stale or beyond the claimed gulps.
  function automatic logic [ADDR_W-1:0] pick_free_address();
    int unsigned choice;
    choice = $urandom_range(0, 11);
    if (choice <= 6 && owned_slabs.size() > 0)
      return slab_addr(owned_slabs[$urandom_range(0, owned_slabs.size() - 1)]);
    case (choice)
      7:       return '0;
      8:       return $urandom;
      9:       return slab_addr($urandom_range(0, TOTAL_SLABS - 1)) +
                      ADDR_W'($urandom_range(1, SLAB_BYTES - 1));
      default: return slab_addr($urandom_range(0, TOTAL_SLABS - 1));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    // Every mismatch is counted, but the log is kept to a readable length.
    if (mismatches < REPORT_CAP)
      $display("ERROR at %0t: %s is %0h, predicted %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Lowers the input valid at the next falling edge, so that the item just
  // accepted is not offered a second time.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sends one item, with a random pause beforehand when the sender idles,
  // and records the predicted result once the block has taken it.
  task automatic send_item(input logic op_i, input logic [ADDR_W-1:0] addr_i,
                           output slab_result_t predicted);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      release_input();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= op_i;
    address  <= addr_i;
    do @(posedge clk); while (!in_ready);
    predicted = predict_slab_result(op_i, addr_i);
    pending_slab_results = {pending_slab_results, predicted};
    items_sent++;
    if (op_i == OP_ALLOC) allocs_sent++;
    else frees_sent++;
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic wait_drained();
    release_input();
    while (pending_slab_results.size() != 0) @(posedge clk);
  endtask

  // Moves the base register; only ever done with the block idle.
  task automatic write_base(input logic [ADDR_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    mirror_base = value;
    base_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A mix of allocates and frees; alloc_pct sets how often an item allocates.
  task automatic run_random_traffic(input int unsigned count, input int unsigned alloc_pct);
    slab_result_t got;
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) send_item(OP_ALLOC, $urandom, got);
      else send_item(OP_FREE, pick_free_address(), got);
    end
  endtask

  // Each check of a free in turn, the refill of the first gulp, and the
  // extremes of the address field, all at the reset base.
  task automatic test_directed();
    slab_result_t      got;
    logic [ADDR_W-1:0] top;
    send_item(OP_FREE, '0, got);                       // null free
    send_item(OP_FREE, mirror_base, got);              // nothing claimed yet
    send_item(OP_ALLOC, '1, got);                      // claims the first gulp
    top = got.slab_address;
    send_item(OP_FREE, top, got);                      // back on the stack
    send_item(OP_FREE, top, got);                      // stack already full
    send_item(OP_ALLOC, '0, got);
    send_item(OP_ALLOC, 32'h5A5A_A5A5, got);
    send_item(OP_FREE, top, got);
    send_item(OP_FREE, top, got);                      // double free
    send_item(OP_FREE, slab_addr(SLABS_PER_GULP), got); // first slab past the claim
    send_item(OP_FREE, mirror_base + 1, got);          // misaligned
    send_item(OP_FREE, '1, got);
    send_item(OP_FREE, mirror_base - SLAB_BYTES, got); // offset wraps below base
    send_item(OP_FREE, 32'h8000_0000, got);
    send_item(OP_FREE, slab_addr(SLABS_PER_GULP - 2), got);
    send_item(OP_FREE, slab_addr(SLABS_PER_GULP - 1) + ADDR_W'(SLAB_BYTES / 2), got);
  endtask

  // Places the base so that the next slab to be handed out sits at address
  // zero: the allocate must succeed, while a free of zero is still null.
  task automatic test_null_slab_wrap();
    slab_result_t got;
    int unsigned  next_idx;
    wait_drained();
    if (mirror_depth > 0) next_idx = mirror_stack[mirror_depth - 1];
    else next_idx = mirror_gulps * SLABS_PER_GULP + SLABS_PER_GULP - 1;
    write_base(ADDR_W'(0 - next_idx * SLAB_BYTES));
    send_item(OP_ALLOC, $urandom, got);
    send_item(OP_FREE, '0, got);
    send_item(OP_FREE, slab_addr(next_idx + 1), got);
  endtask

  // Runs traffic under a base of one and the largest base, a random nonzero one
  // and a chunk-aligned random one. Allocates are favoured a little so
  // that further gulps get claimed along the way.
  task automatic test_base_settings();
    write_base(32'h0000_0001);
    run_random_traffic(25, 60);
    write_base(32'hFFFF_FFFF);
    run_random_traffic(25, 60);
    write_base($urandom_range(1, 32'hFFFF_FFFF));
    run_random_traffic(25, 60);
    write_base(ADDR_W'({$urandom_range(1, 32'h003F_FFFF), 10'b0}));
    run_random_traffic(25, 60);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items back to back, so the block fills and stalls its input.
  // The sender then waits until every result has been taken.
  task automatic test_backpressure();
    wait_drained();
    tx_idle_en = 1'b0;
    rx_hold_request = 150;
    run_random_traffic(12, 50);
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_random_traffic(200, 50);
  endtask

  // Allocates until every gulp is claimed and the allocator refuses a few
  // times, then frees everything again and overfills the stack once.
  task automatic test_exhaustion();
    slab_result_t got;
    int unsigned  refusals;
    int unsigned  tries;
    refusals = 0;
    tries = 0;
    write_base(ADDR_W'({$urandom_range(1, 32'h003F_0000), 10'b0}));
    while (refusals < 3 && tries < 2 * TOTAL_SLABS) begin
      send_item(OP_ALLOC, $urandom, got);
      if (got.status == ST_NO_GULPS) refusals++;
      tries++;
    end
    tries = 0;
    while (owned_slabs.size() > 0 && tries < 3 * TOTAL_SLABS) begin
      send_item(OP_FREE, slab_addr(owned_slabs[$urandom_range(0, owned_slabs.size() - 1)]),
                got);
      tries++;
    end
    send_item(OP_FREE, slab_addr(0), got);
  endtask

  // Back at the reset base with no idling on either side.
  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_base(BASE_RESET);
    run_random_traffic(80, 50);
  endtask

  // Result receiver: random stall bursts, a counted long hold-off when one
  // is asked for, and otherwise ready.
  initial begin : result_receiver
    int unsigned hold_left;
    int unsigned burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request > 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
        out_ready <= 1'b0;
        while (hold_left > 1) begin
          @(negedge clk);
          hold_left--;
        end
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compares every result taken from the block with the oldest prediction.
  always @(posedge clk) begin : result_check
    slab_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_slab_results.size() == 0) begin
        report_mismatch("unexpected result, status", ADDR_W'(status), '0);
      end else begin
        want = pending_slab_results[0];
        pending_slab_results.delete(0);
        results_checked++;
        if (want.status < 6) status_seen[want.status]++;
        if (status !== want.status)
          report_mismatch("status", ADDR_W'(status), ADDR_W'(want.status));
        if (slab_address !== want.slab_address)
          report_mismatch("slab_address", slab_address, want.slab_address);
        if (free_count !== want.free_count)
          report_mismatch("free_count", ADDR_W'(free_count), ADDR_W'(want.free_count));
        if (gulps_claimed !== want.gulps_claimed)
          report_mismatch("gulps_claimed", ADDR_W'(gulps_claimed),
                          ADDR_W'(want.gulps_claimed));
      end
    end
  end

  initial begin : stimulus
    int k;
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_ALLOC;
    address   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_request = 0;
    mismatches = 0;
    items_sent = 0;
    allocs_sent = 0;
    frees_sent = 0;
    base_writes = 0;
    results_checked = 0;
    for (k = 0; k < 6; k++) status_seen[k] = 0;
    // The mirror starts as the block does after reset: empty stack, no
    // gulps, no marks, the reset base. The stack itself is left unset.
    mirror_base  = BASE_RESET;
    mirror_depth = '0;
    mirror_gulps = '0;
    for (k = 0; k < TOTAL_SLABS; k++) mirror_mark[k] = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_null_slab_wrap();
    test_base_settings();
    test_backpressure();
    test_random_traffic();
    test_exhaustion();
    test_steady_stream();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d allocates, %0d frees), %0d base writes, %0d cycles.",
             items_sent, allocs_sent, frees_sent, base_writes, cycle_count);
    $display("Results by status: ok %0d, null %0d, outside %0d, full %0d, double %0d, %s %0d.",
             status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_OUTSIDE],
             status_seen[ST_FULL], status_seen[ST_DOUBLE], "no gulps",
             status_seen[ST_NO_GULPS]);
    if (mismatches == 0) begin
      $display("slab_free_list_allocator_unit: match");
    end else begin
      $display("slab_free_list_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_alu.sv
rtl/slab_free_list_allocator_unit.sv
dv/tb_slab_free_list_allocator_unit.sv
